>>> src/assert_macros.svh
// assertion macros shared by the modular matrix-vector block
// no dependencies; taken in by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge, off during reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/mmpe_pkg.sv
// shared constants, types and controller codes of the modular matrix-vector block
// no dependencies; used by every other file of the block but assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

package mmpe_pkg;

    // field widths
    localparam int LANES       = 8;
    localparam int LANE_IDX_W  = $clog2(LANES);
    localparam int LANE_W      = 16;
    localparam int GROUP_W     = 6;
    localparam int ROW_W       = 9;
    localparam int MOD_W       = 16;
    localparam logic [MOD_W-1:0] MOD_RESET = 16'd65521;

    // datapath widths: products, pair sums, quad sums, reducer dividend
    localparam int PROD_W  = 2 * LANE_W;
    localparam int PAIR_W  = PROD_W + 2;
    localparam int QUAD_W  = PAIR_W + 1;
    localparam int DIV_W   = QUAD_W + 1;
    localparam int DIGITS  = DIV_W / 2;
    localparam int CNT_W   = $clog2(DIGITS);
    localparam int TRIAL_W = MOD_W + 2;

    // default sizes
    localparam int VECTOR_LENGTH_DEF = 512;
    localparam int ROW_COUNT_DEF     = 512;

    // request action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MUL  = 1'b1;

    typedef logic [LANES-1:0][LANE_W-1:0] lane_vec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD1,
        ST_ADD2,
        ST_LOAD_SUM,
        ST_RED_SUM,
        ST_LOAD_FIN,
        ST_RED_FIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_secret;
        logic capture;
        logic mul_en;
        logic add1_en;
        logic add2_en;
        logic red_start;
        logic red_sel_fin;
        logic acc_update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic red_busy;
        logic row_end;
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

>>> src/mmpe_if.sv
// channel interfaces: request in, row result out, modulus write
// depends on mmpe_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface mmpe_item_if import mmpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [GROUP_W-1:0]   group_index;
    logic [LANE_W-1:0]    lane_0;
    logic [LANE_W-1:0]    lane_1;
    logic [LANE_W-1:0]    lane_2;
    logic [LANE_W-1:0]    lane_3;
    logic [LANE_W-1:0]    lane_4;
    logic [LANE_W-1:0]    lane_5;
    logic [LANE_W-1:0]    lane_6;
    logic [LANE_W-1:0]    lane_7;
    logic [LANE_W-1:0]    error_term;
    logic                 row_end;

    modport source (
        output valid, action, group_index, lane_0, lane_1, lane_2, lane_3,
               lane_4, lane_5, lane_6, lane_7, error_term, row_end,
        input  ready
    );
    modport sink (
        input  valid, action, group_index, lane_0, lane_1, lane_2, lane_3,
               lane_4, lane_5, lane_6, lane_7, error_term, row_end,
        output ready
    );
endinterface

interface mmpe_result_if import mmpe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_number;
    logic [LANE_W-1:0]  row_value;

    modport source (output valid, row_number, row_value, input ready);
    modport sink (input valid, row_number, row_value, output ready);
endinterface

interface mmpe_cfg_if import mmpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MOD_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/mmpe_reduce.sv
// iterative remainder unit: dividend mod q, two dividend bits per cycle
// depends on mmpe_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mmpe_reduce import mmpe_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_W-1:0]   dividend,
    input  wire logic [MOD_W-1:0]   modulus,
    output logic                    busy,
    output logic [MOD_W-1:0]        remainder
);

    logic [TRIAL_W-1:0] q1_reg, q2_reg, q3_reg;
    logic [TRIAL_W-1:0] q1_next;
    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MOD_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   shift_reg;
    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] diff;

    // effective divisor, a zero modulus stands for 2^16
    assign q1_next = (modulus == '0) ? TRIAL_W'(1) << MOD_W : TRIAL_W'(modulus);

    // divisor multiples, refreshed every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_reg <= TRIAL_W'(MOD_RESET);
            q2_reg <= TRIAL_W'(MOD_RESET) << 1;
            q3_reg <= TRIAL_W'(MOD_RESET) + (TRIAL_W'(MOD_RESET) << 1);
        end
        else
        begin
            q1_reg <= q1_next;
            q2_reg <= q1_next << 1;
            q3_reg <= q1_next + (q1_next << 1);
        end
    end

    // one radix-4 digit step: shift in two bits, subtract the largest fitting multiple
    always_comb
    begin
        trial = {rem_reg, shift_reg[DIV_W-1 -: 2]};
        if (trial >= q3_reg)
        begin
            diff = trial - q3_reg;
        end
        else if (trial >= q2_reg)
        begin
            diff = trial - q2_reg;
        end
        else if (trial >= q1_reg)
        begin
            diff = trial - q1_reg;
        end
        else
        begin
            diff = trial;
        end
        rem_next = diff[MOD_W-1:0];
    end

    // step control and partial remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend shifter
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DIV_W-3:0], 2'b00};
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

    `ASSERT_IMPLIES(a_rem_below_divisor, clk, rst_n, busy_reg, ({2'b00, rem_reg} < q1_reg), "partial remainder not below divisor")
    `ASSERT_CLK(a_last_step_ends, clk, rst_n, (busy_reg && !start && cnt_reg == CNT_W'(DIGITS - 1)) |=> !busy_reg, "reducer still busy after last digit")

endmodule

`default_nettype wire

>>> src/mmpe_datapath.sv
// datapath: secret store, lane multipliers, adder tree, accumulator,
// row counter, output register and modulus register; uses mmpe_reduce
// depends on mmpe_pkg, mmpe_reduce and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mmpe_datapath import mmpe_pkg::*; #(
    parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF,
    parameter int ROW_COUNT     = ROW_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output status_t                  status,
    input  wire logic [GROUP_W-1:0]  group_index,
    input  wire lane_vec_t           lanes,
    input  wire logic [LANE_W-1:0]   error_term,
    input  wire logic                row_end,
    input  wire logic                cfg_valid,
    input  wire logic [MOD_W-1:0]    cfg_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [ROW_W-1:0]         row_number,
    output logic [LANE_W-1:0]        row_value
);

    localparam int GROUPS_ALL = (VECTOR_LENGTH + LANES - 1) / LANES;
    localparam int MEM_ROWS   = (GROUPS_ALL < (2 ** GROUP_W)) ? GROUPS_ALL : (2 ** GROUP_W);
    localparam int ADDR_W     = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;

    lane_vec_t               secret_mem [MEM_ROWS];
    lane_vec_t               secret_rd_reg;
    lane_vec_t               lane_reg;
    logic [LANES-1:0]        lane_ok;
    logic [LANES-1:0]        mask_reg;
    logic                    addr_ok;
    logic [ADDR_W-1:0]       mem_addr;
    logic [LANE_W-1:0]       err_reg;
    logic                    row_end_reg;
    logic [PROD_W-1:0]       prod_reg [LANES];
    logic [PAIR_W-1:0]       pair_reg [LANES/2];
    logic [QUAD_W-1:0]       quad_reg [LANES/4];
    logic [MOD_W-1:0]        acc_reg;
    logic [MOD_W-1:0]        modulus_reg;
    logic [ROW_W-1:0]        row_cnt_reg, row_cnt_next;
    logic [ROW_W:0]          row_cnt_inc;
    logic                    out_valid_reg;
    logic [ROW_W-1:0]        row_number_reg;
    logic [LANE_W-1:0]       row_value_reg;
    logic [DIV_W-1:0]        dividend;
    logic                    red_busy;
    logic [MOD_W-1:0]        red_rem;

    // lanes whose column lies inside the vector
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_ok[l] = (32'({group_index, LANE_IDX_W'(l)}) < 32'(VECTOR_LENGTH));
        end
    end

    assign addr_ok  = (32'(group_index) < 32'(MEM_ROWS));
    assign mem_addr = addr_ok ? group_index[ADDR_W-1:0] : '0;

    // secret store: lane-enabled write on load, registered row read on capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_secret && addr_ok)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (lane_ok[l])
                begin
                    secret_mem[mem_addr][l] <= lanes[l];
                end
            end
        end
        if (cmd.capture)
        begin
            secret_rd_reg <= secret_mem[mem_addr];
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lane_reg <= lanes;
            mask_reg <= lane_ok;
            err_reg  <= error_term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_end_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            row_end_reg <= row_end;
        end
    end

    // lane products, masked lanes give zero
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                prod_reg[l] <= mask_reg[l] ?
                    PROD_W'(lane_reg[l]) * PROD_W'(secret_rd_reg[l]) : '0;
            end
        end
    end

    // adder tree, first level also takes the running accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.add1_en)
        begin
            for (int i = 0; i < LANES / 2; i++)
            begin
                pair_reg[i] <= PAIR_W'(prod_reg[2*i]) + PAIR_W'(prod_reg[2*i+1])
                    + ((i == 0) ? PAIR_W'(acc_reg) : '0);
            end
        end
        if (cmd.add2_en)
        begin
            for (int j = 0; j < LANES / 4; j++)
            begin
                quad_reg[j] <= QUAD_W'(pair_reg[2*j]) + QUAD_W'(pair_reg[2*j+1]);
            end
        end
    end

    // reducer input: row sum, or accumulator plus error on the last request
    assign dividend = cmd.red_sel_fin ?
        (DIV_W'(acc_reg) + DIV_W'(err_reg)) :
        (DIV_W'(quad_reg[0]) + DIV_W'(quad_reg[1]));

    mmpe_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.red_start),
        .dividend  (dividend),
        .modulus   (modulus_reg),
        .busy      (red_busy),
        .remainder (red_rem)
    );

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_valid)
        begin
            modulus_reg <= cfg_data;
        end
    end

    // row counter wraps at the row count and within its width
    assign row_cnt_inc  = {1'b0, row_cnt_reg} + (ROW_W + 1)'(1);
    assign row_cnt_next = (32'(row_cnt_inc) >= 32'(ROW_COUNT)) ? '0 : row_cnt_inc[ROW_W-1:0];

    // accumulator, row counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_update)
            begin
                acc_reg <= red_rem;
            end
            else if (cmd.out_load)
            begin
                acc_reg <= '0;
            end
            if (cmd.out_load)
            begin
                row_cnt_reg   <= row_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            row_number_reg <= row_cnt_reg;
            row_value_reg  <= red_rem;
        end
    end

    assign out_valid       = out_valid_reg;
    assign row_number      = row_number_reg;
    assign row_value       = row_value_reg;
    assign status.red_busy = red_busy;
    assign status.row_end  = row_end_reg;
    assign status.out_full = out_valid_reg;

    `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg, "row result loaded over a pending result")

endmodule

`default_nettype wire

>>> src/mmpe_ctrl.sv
// controller state machine: issues secret loads and sequences capture, multiply, add, reduce and emit
// depends on mmpe_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mmpe_ctrl import mmpe_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    input  wire logic     item_action,
    output logic          item_ready,
    input  wire status_t  status,
    output cmd_t          cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_action == ACT_MUL)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        cmd.load_secret = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                cmd.add1_en = 1'b1;
                state_next  = ST_ADD2;
            end
            ST_ADD2:
            begin
                cmd.add2_en = 1'b1;
                state_next  = ST_LOAD_SUM;
            end
            ST_LOAD_SUM:
            begin
                cmd.red_start = 1'b1;
                state_next    = ST_RED_SUM;
            end
            ST_RED_SUM:
            begin
                if (!status.red_busy)
                begin
                    cmd.acc_update = 1'b1;
                    state_next     = status.row_end ? ST_LOAD_FIN : ST_IDLE;
                end
            end
            ST_LOAD_FIN:
            begin
                cmd.red_start   = 1'b1;
                cmd.red_sel_fin = 1'b1;
                state_next      = ST_RED_FIN;
            end
            ST_RED_FIN:
            begin
                if (!status.red_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_start_when_idle, clk, rst_n, cmd.red_start, !status.red_busy, "reducer started while busy")
    `ASSERT_CLK(a_sum_leads_to_reduce, clk, rst_n, (state_reg == ST_LOAD_SUM) |=> status.red_busy, "reducer did not start on row sum")

endmodule

`default_nettype wire

>>> src/modular_matvec_plus_error_unit.sv
// top level of the modular matrix-vector multiply plus error block
// depends on mmpe_pkg, the mmpe_if interfaces, mmpe_ctrl and mmpe_datapath
//
// Usage: requests arrive on item (valid/ready). A load request (action 0)
// writes those of its eight secret elements inside the vector at its
// group, and the block stays ready. A multiply request (action 1)
// runs through the lane multipliers and a two-level adder tree, then the
// sum is reduced modulo the modulus by a remainder unit that settles two
// bits per cycle over 18 steps. A multiply request holds the block until
// that is done; the last request of a row adds its error term and takes a
// second pass through the same unit, then its row result shows on result
// (valid/ready) with its row number before a next request is taken.
// The modulus is written on cfg, always ready; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Reset clears the accumulator and row counter and sets the modulus to
// 65521; the secret store holds no value until loaded.
// A stalled result waits in the output register; further requests are still
// taken and only the next row result waits until the pending one is taken.
`timescale 1ns / 1ps
`default_nettype none

module modular_matvec_plus_error_unit import mmpe_pkg::*; #(
    parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF,
    parameter int ROW_COUNT     = ROW_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mmpe_item_if.sink       item,
    mmpe_result_if.source   result,
    mmpe_cfg_if.sink        cfg
);

    cmd_t      cmd;
    status_t   status;
    lane_vec_t lanes;

    // request lanes as one vector
    assign lanes = {item.lane_7, item.lane_6, item.lane_5, item.lane_4,
                    item.lane_3, item.lane_2, item.lane_1, item.lane_0};

    // modulus writes are always taken
    assign cfg.ready = 1'b1;

    mmpe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .status      (status),
        .cmd         (cmd)
    );

    mmpe_datapath #(
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .ROW_COUNT     (ROW_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .group_index (item.group_index),
        .lanes       (lanes),
        .error_term  (item.error_term),
        .row_end     (item.row_end),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.data),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .row_number  (result.row_number),
        .row_value   (result.row_value)
    );

endmodule

`default_nettype wire
